### rtl/core/accel_axis_alignment_projector_assert.svh
// assertion macros shared by the alignment projector rtl
`ifndef ACCEL_AXIS_ALIGNMENT_PROJECTOR_ASSERT_SVH
`define ACCEL_AXIS_ALIGNMENT_PROJECTOR_ASSERT_SVH

// same-cycle implication, held off while in reset
`define AAP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("alignment projector assertion failed");

// next-cycle implication, held off while in reset
`define AAP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("alignment projector assertion failed");

`endif

### rtl/core/aap_pkg.sv
// shared constants, codes and types of the alignment projector
package aap_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int AXIS_FRAC_BITS_DEF = 15;

  // vectors are shrunk below 2^NORM_BITS before normalising
  localparam int NORM_BITS   = 24;
  localparam int MUL_W       = NORM_BITS + 1;
  localparam int ACC_W       = 2 * MUL_W + 2;
  localparam int OUT_BITS    = 16;
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_UNCAL  = 2'd2
  } status_e;

  typedef enum logic {
    OP_CAL  = 1'b0,
    OP_MEAS = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e op;
  } mac_ctrl_t;

  // operand order of the six cross product terms: c0 = a1b2 - a2b1, ...
  function automatic logic [1:0] cross_a_idx(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b_idx(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/aap_chan_if.sv
// request and result channel interfaces of the alignment projector
interface aap_in_if #(
  parameter int SampleBits = aap_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [SampleBits-1:0] vec_x;
  logic signed [SampleBits-1:0] vec_y;
  logic signed [SampleBits-1:0] vec_z;
  logic signed [SampleBits-1:0] ref_x;
  logic signed [SampleBits-1:0] ref_y;
  logic signed [SampleBits-1:0] ref_z;

  modport source (
    output valid, opcode, vec_x, vec_y, vec_z, ref_x, ref_y, ref_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, vec_x, vec_y, vec_z, ref_x, ref_y, ref_z,
    output ready
  );
endinterface

interface aap_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [aap_pkg::OUT_BITS-1:0]  vertical_g;
  logic signed [aap_pkg::OUT_BITS-1:0]  forward_g;
  logic signed [aap_pkg::OUT_BITS-1:0]  lateral_g;
  logic [aap_pkg::STATUS_BITS-1:0]      status;
  logic                                 saturated;

  modport source (
    output valid, vertical_g, forward_g, lateral_g, status, saturated,
    input  ready
  );
  modport sink (
    input  valid, vertical_g, forward_g, lateral_g, status, saturated,
    output ready
  );
endinterface

### rtl/core/aap_mac.sv
// shared signed multiplier with registered product and accumulator
module aap_mac (
  input  logic                                clk_i,
  input  aap_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [aap_pkg::MUL_W-1:0]    a_i,
  input  logic signed [aap_pkg::MUL_W-1:0]    b_i,
  output logic signed [aap_pkg::ACC_W-1:0]    acc_o
);

  localparam int MulW = aap_pkg::MUL_W;
  localparam int AccW = aap_pkg::ACC_W;

  logic signed [2*MulW-1:0] prod_q;
  logic signed [AccW-1:0]   prod_ext;
  logic signed [AccW-1:0]   acc_d;
  logic signed [AccW-1:0]   acc_q;

  assign prod_ext = {{(AccW-2*MulW){prod_q[2*MulW-1]}}, prod_q};

  always_comb begin
    case (ctrl_i.op)
      aap_pkg::ACC_LOAD: acc_d = prod_ext;
      aap_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      aap_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### rtl/core/accel_axis_alignment_projector.sv
// top level of the accelerometer to vehicle frame alignment projector
// A calibrate beat (opcode 0) takes a vertical reference and a tilted
// vertical-forward reference and derives three unit axes (vertical, forward,
// lateral) with AXIS_FRAC_BITS fraction bits; a zero vertical or parallel
// references give status 1 and keep the old axes. A measure beat (opcode 1)
// returns the sample projected on the three axes, rounded and clipped to 16
// bits with a saturation flag, or status 2 before the first calibration.
// One beat is worked at a time on a single multiplier/accumulator, a bitwise
// square root and a restoring divider under a one-hot sequencer; the request
// channel is ready only while the sequencer is idle. A measure runs three
// 3-term dot products (a multiply and an accumulate per term, one rounding
// step each) and then loads the result. A calibrate runs the cross
// products, one halving step per halving of the oversized cross products,
// and per axis the square root (26 steps) and the divider (F+1 steps per
// component). The result register lets the next beat be accepted while a
// result still waits.
`include "accel_axis_alignment_projector_assert.svh"

module accel_axis_alignment_projector #(
  parameter int SAMPLE_BITS    = aap_pkg::SAMPLE_BITS_DEF,
  parameter int AXIS_FRAC_BITS = aap_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aap_in_if.sink    in_i,
  aap_out_if.source out_o
);

  localparam int SW     = SAMPLE_BITS;
  localparam int F      = AXIS_FRAC_BITS;
  localparam int NormW  = aap_pkg::NORM_BITS;
  localparam int MulW   = aap_pkg::MUL_W;
  localparam int AccW   = aap_pkg::ACC_W;
  localparam int OutW   = aap_pkg::OUT_BITS;
  localparam int WmagW  = AccW - 1;
  localparam int RtW    = NormW + 1;
  localparam int DivW   = RtW + 1 + F;
  localparam int QW     = F + 1;
  localparam int AxW    = F + 1;
  localparam int DcW    = $clog2(F + 1);

  localparam logic [2:0]      LastProd = 3'd5;
  localparam logic [2:0]      LastComp = 3'd2;
  localparam logic [1:0]      LastAxis = 2'd2;
  localparam logic [1:0]      PhMul    = 2'd0;
  localparam logic [1:0]      PhAcc    = 2'd1;
  localparam logic [1:0]      PhSt     = 2'd2;
  localparam logic [1:0]      AxVert   = 2'd0;
  localparam logic [1:0]      AxFwd    = 2'd1;
  localparam logic [1:0]      AxLat    = 2'd2;
  localparam logic [AccW-1:0] PosLim   = AccW'((64'd1 << (OutW-1)) - 64'd1);
  localparam logic [AccW-1:0] NegLim   = AccW'(64'd1 << (OutW-1));
  localparam logic [AccW-1:0] RndHalf  = AccW'(64'd1 << (F-1));
  localparam logic [AccW-1:0] RootTop  = AccW'(64'd1 << (AccW-2));

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CROSS  = 12'b0000_0000_0010,
    S_CHECK  = 12'b0000_0000_0100,
    S_SHRINK = 12'b0000_0000_1000,
    S_SQ     = 12'b0000_0001_0000,
    S_RTL    = 12'b0000_0010_0000,
    S_ROOT   = 12'b0000_0100_0000,
    S_DIVL   = 12'b0000_1000_0000,
    S_DIV    = 12'b0001_0000_0000,
    S_PROJ   = 12'b0010_0000_0000,
    S_RND    = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  // which vector the shared datapath is working on during a calibrate
  typedef enum logic [3:0] {
    P_LAT   = 4'b0001,
    P_FWD   = 4'b0010,
    P_VERT  = 4'b0100,
    P_LATAX = 4'b1000
  } pass_e;

  // control state
  state_e           state_q, state_d;
  pass_e            pass_q, pass_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       ph_q, ph_d;
  logic [1:0]       ai_q, ai_d;
  logic [DcW-1:0]   dc_q, dc_d;
  logic             cal_q, cal_d;
  logic             ov_q, ov_d;
  logic signed [AxW-1:0] ax_q [3][3];
  logic signed [AxW-1:0] ax_d [3][3];

  // operands and working registers
  logic signed [SW-1:0]  v_q [3];
  logic signed [SW-1:0]  v_d [3];
  logic signed [SW-1:0]  r_q [3];
  logic signed [SW-1:0]  r_d [3];
  logic                  w_neg_q [3];
  logic                  w_neg_d [3];
  logic [WmagW-1:0]      w_mag_q [3];
  logic [WmagW-1:0]      w_mag_d [3];
  logic                  l_neg_q [3];
  logic                  l_neg_d [3];
  logic [NormW-1:0]      l_mag_q [3];
  logic [NormW-1:0]      l_mag_d [3];
  logic [AccW-1:0]       rt_rem_q, rt_rem_d;
  logic [AccW-1:0]       rt_res_q, rt_res_d;
  logic [AccW-1:0]       rt_bit_q, rt_bit_d;
  logic [DivW-1:0]       dv_rem_q, dv_rem_d;
  logic [DivW-1:0]       dv_sh_q, dv_sh_d;
  logic [QW-1:0]         dv_quo_q, dv_quo_d;
  logic signed [OutW-1:0] g_q [3];
  logic signed [OutW-1:0] g_d [3];
  logic                  sat_q, sat_d;
  aap_pkg::status_e      st_q, st_d;

  // result register
  logic signed [OutW-1:0] og_q [3];
  logic signed [OutW-1:0] og_d [3];
  aap_pkg::status_e      ost_q, ost_d;
  logic                  osat_q, osat_d;

  // shared multiplier/accumulator
  aap_pkg::mac_ctrl_t    mac_ctrl;
  logic signed [MulW-1:0] mac_a, mac_b;
  logic signed [AccW-1:0] acc;

  // helpers
  logic [1:0]            ja, jb, ci, ax_sel;
  logic [SW-1:0]         v_abs [3];
  logic                  v_zero, w_zero, w_big;
  logic [AccW-1:0]       acc_abs;
  logic [AccW-1:0]       rnd_q;
  logic                  rnd_sat;
  logic signed [OutW-1:0] rnd_val;
  logic [AccW-1:0]       rt_try;
  logic                  rt_ge;
  logic [RtW-1:0]        n_div;
  logic                  dv_ge;
  logic [QW-1:0]         dv_quo_new;
  logic [QW-1:0]         dv_clip;
  logic signed [AxW-1:0] ax_val;
  logic signed [MulW-1:0] l_op;

  assign ja = aap_pkg::cross_a_idx(cnt_q);
  assign jb = aap_pkg::cross_b_idx(cnt_q);
  assign ci = cnt_q[1:0];

  always_comb begin
    v_zero = 1'b1;
    w_zero = 1'b1;
    w_big  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v_abs[i] = v_q[i][SW-1] ? SW'(-v_q[i]) : v_q[i];
      v_zero   = v_zero & (v_q[i] == '0);
      w_zero   = w_zero & (w_mag_q[i] == '0);
      w_big    = w_big | (|w_mag_q[i][WmagW-1:NormW]);
    end
  end

  always_comb begin
    case (pass_q)
      P_FWD:   ax_sel = AxFwd;
      P_LATAX: ax_sel = AxLat;
      default: ax_sel = AxVert;
    endcase
  end

  // magnitude of the accumulator, rounding and clipping of a projection
  assign acc_abs = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
  assign rnd_q   = (acc_abs + RndHalf) >> F;

  always_comb begin
    if (acc[AccW-1]) begin
      rnd_sat = rnd_q > NegLim;
      rnd_val = rnd_sat ? {1'b1, {(OutW-1){1'b0}}} : -$signed(rnd_q[OutW-1:0]);
    end else begin
      rnd_sat = rnd_q > PosLim;
      rnd_val = rnd_sat ? {1'b0, {(OutW-1){1'b1}}} : $signed(rnd_q[OutW-1:0]);
    end
  end

  // square root step, one result bit per cycle
  assign rt_try = rt_res_q + rt_bit_q;
  assign rt_ge  = rt_rem_q >= rt_try;

  // restoring divide step, rounded quotient clipped below one
  assign n_div      = (rt_res_q[RtW-1:0] == '0) ? RtW'(1) : rt_res_q[RtW-1:0];
  assign dv_ge      = dv_rem_q >= dv_sh_q;
  assign dv_quo_new = {dv_quo_q[QW-2:0], dv_ge};
  assign dv_clip    = dv_quo_new[QW-1] ? {1'b0, {F{1'b1}}} : dv_quo_new;
  assign ax_val     = w_neg_q[ci] ? -$signed(dv_clip) : $signed(dv_clip);

  // stored lateral direction as a signed operand
  always_comb begin
    l_op = $signed({1'b0, l_mag_q[ja]});
    if (l_neg_q[ja]) begin
      l_op = -l_op;
    end
  end

  // operand selection for the shared unit
  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.op     = aap_pkg::ACC_HOLD;
    mac_a           = '0;
    mac_b           = '0;
    case (state_q)
      S_CROSS: begin
        if (pass_q == P_LAT) begin
          mac_a = {{(MulW-SW){v_q[ja][SW-1]}}, v_q[ja]};
          mac_b = {{(MulW-SW){r_q[jb][SW-1]}}, r_q[jb]};
        end else begin
          mac_a = l_op;
          mac_b = {{(MulW-SW){v_q[jb][SW-1]}}, v_q[jb]};
        end
        mac_ctrl.mul_en = (ph_q == PhMul);
        if (ph_q == PhAcc) begin
          mac_ctrl.op = cnt_q[0] ? aap_pkg::ACC_SUB : aap_pkg::ACC_LOAD;
        end
      end
      S_SQ: begin
        mac_a           = $signed({1'b0, w_mag_q[ci][NormW-1:0]});
        mac_b           = $signed({1'b0, w_mag_q[ci][NormW-1:0]});
        mac_ctrl.mul_en = (ph_q == PhMul);
        if (ph_q == PhAcc) begin
          mac_ctrl.op = (cnt_q == '0) ? aap_pkg::ACC_LOAD : aap_pkg::ACC_ADD;
        end
      end
      S_PROJ: begin
        mac_a           = {{(MulW-SW){v_q[ci][SW-1]}}, v_q[ci]};
        mac_b           = {{(MulW-AxW){ax_q[ai_q][ci][AxW-1]}}, ax_q[ai_q][ci]};
        mac_ctrl.mul_en = (ph_q == PhMul);
        if (ph_q == PhAcc) begin
          mac_ctrl.op = (cnt_q == '0) ? aap_pkg::ACC_LOAD : aap_pkg::ACC_ADD;
        end
      end
      default: begin
        mac_ctrl.mul_en = 1'b0;
      end
    endcase
  end

  aap_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    ai_d     = ai_q;
    dc_d     = dc_q;
    cal_d    = cal_q;
    ov_d     = ov_q;
    ax_d     = ax_q;
    v_d      = v_q;
    r_d      = r_q;
    w_neg_d  = w_neg_q;
    w_mag_d  = w_mag_q;
    l_neg_d  = l_neg_q;
    l_mag_d  = l_mag_q;
    rt_rem_d = rt_rem_q;
    rt_res_d = rt_res_q;
    rt_bit_d = rt_bit_q;
    dv_rem_d = dv_rem_q;
    dv_sh_d  = dv_sh_q;
    dv_quo_d = dv_quo_q;
    g_d      = g_q;
    sat_d    = sat_q;
    st_d     = st_q;
    og_d     = og_q;
    ost_d    = ost_q;
    osat_d   = osat_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          v_d[0] = in_i.vec_x;
          v_d[1] = in_i.vec_y;
          v_d[2] = in_i.vec_z;
          r_d[0] = in_i.ref_x;
          r_d[1] = in_i.ref_y;
          r_d[2] = in_i.ref_z;
          for (int i = 0; i < 3; i++) begin
            g_d[i] = '0;
          end
          sat_d = 1'b0;
          st_d  = aap_pkg::ST_OK;
          cnt_d = '0;
          ph_d  = PhMul;
          ai_d  = '0;
          if (in_i.opcode == aap_pkg::OP_CAL) begin
            pass_d  = P_LAT;
            state_d = S_CROSS;
          end else if (!cal_q) begin
            st_d    = aap_pkg::ST_UNCAL;
            state_d = S_DONE;
          end else begin
            state_d = S_PROJ;
          end
        end
      end

      // v x r, then latr x v; odd terms close a component
      S_CROSS: begin
        case (ph_q)
          PhMul: ph_d = PhAcc;
          PhAcc: begin
            if (cnt_q[0]) begin
              ph_d = PhSt;
            end else begin
              cnt_d = cnt_q + 3'd1;
              ph_d  = PhMul;
            end
          end
          default: begin
            w_neg_d[cnt_q[2:1]] = acc[AccW-1];
            w_mag_d[cnt_q[2:1]] = acc_abs[WmagW-1:0];
            ph_d                = PhMul;
            if (cnt_q == LastProd) begin
              cnt_d   = '0;
              state_d = (pass_q == P_LAT) ? S_CHECK : S_SHRINK;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
        endcase
      end

      S_CHECK: begin
        if (v_zero || w_zero) begin
          st_d    = aap_pkg::ST_REJECT;
          state_d = S_DONE;
        end else begin
          state_d = S_SHRINK;
        end
      end

      // halve magnitudes until all fit the normalising range
      S_SHRINK: begin
        if (w_big) begin
          for (int i = 0; i < 3; i++) begin
            w_mag_d[i] = w_mag_q[i] >> 1;
          end
        end else if (pass_q == P_LAT) begin
          for (int i = 0; i < 3; i++) begin
            l_neg_d[i] = w_neg_q[i];
            l_mag_d[i] = w_mag_q[i][NormW-1:0];
          end
          pass_d  = P_FWD;
          cnt_d   = '0;
          ph_d    = PhMul;
          state_d = S_CROSS;
        end else begin
          cnt_d   = '0;
          ph_d    = PhMul;
          state_d = S_SQ;
        end
      end

      S_SQ: begin
        if (ph_q == PhMul) begin
          ph_d = PhAcc;
        end else begin
          ph_d = PhMul;
          if (cnt_q == LastComp) begin
            cnt_d   = '0;
            state_d = S_RTL;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end

      S_RTL: begin
        rt_rem_d = AccW'(acc);
        rt_res_d = '0;
        rt_bit_d = RootTop;
        state_d  = S_ROOT;
      end

      S_ROOT: begin
        if (rt_ge) begin
          rt_rem_d = rt_rem_q - rt_try;
          rt_res_d = (rt_res_q >> 1) + rt_bit_q;
        end else begin
          rt_res_d = rt_res_q >> 1;
        end
        rt_bit_d = rt_bit_q >> 2;
        if (rt_bit_q[0]) begin
          cnt_d   = '0;
          state_d = S_DIVL;
        end
      end

      S_DIVL: begin
        dv_rem_d = (DivW'(w_mag_q[ci][NormW-1:0]) << (F + 1)) + DivW'(n_div);
        dv_sh_d  = DivW'({n_div, 1'b0}) << F;
        dv_quo_d = '0;
        dc_d     = '0;
        state_d  = S_DIV;
      end

      S_DIV: begin
        dv_rem_d = dv_ge ? (dv_rem_q - dv_sh_q) : dv_rem_q;
        dv_sh_d  = dv_sh_q >> 1;
        dv_quo_d = dv_quo_new;
        dc_d     = DcW'(dc_q + 1'b1);
        if (dc_q == DcW'(F)) begin
          ax_d[ax_sel][ci] = ax_val;
          if (cnt_q == LastComp) begin
            cnt_d = '0;
            ph_d  = PhMul;
            case (pass_q)
              P_FWD: begin
                for (int i = 0; i < 3; i++) begin
                  w_neg_d[i] = v_q[i][SW-1];
                  w_mag_d[i] = WmagW'(v_abs[i]);
                end
                pass_d  = P_VERT;
                state_d = S_SHRINK;
              end
              P_VERT: begin
                for (int i = 0; i < 3; i++) begin
                  w_neg_d[i] = l_neg_q[i];
                  w_mag_d[i] = WmagW'(l_mag_q[i]);
                end
                pass_d  = P_LATAX;
                state_d = S_SHRINK;
              end
              default: begin
                cal_d   = 1'b1;
                state_d = S_DONE;
              end
            endcase
          end else begin
            cnt_d   = cnt_q + 3'd1;
            state_d = S_DIVL;
          end
        end
      end

      S_PROJ: begin
        if (ph_q == PhMul) begin
          ph_d = PhAcc;
        end else begin
          ph_d = PhMul;
          if (cnt_q == LastComp) begin
            cnt_d   = '0;
            state_d = S_RND;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end

      S_RND: begin
        g_d[ai_q] = rnd_val;
        sat_d     = sat_q | rnd_sat;
        if (ai_q == LastAxis) begin
          state_d = S_DONE;
        end else begin
          ai_d    = ai_q + 2'd1;
          state_d = S_PROJ;
        end
      end

      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          og_d    = g_q;
          ost_d   = st_q;
          osat_d  = sat_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= P_LAT;
      cnt_q   <= '0;
      ph_q    <= PhMul;
      ai_q    <= '0;
      dc_q    <= '0;
      cal_q   <= 1'b0;
      ov_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          ax_q[i][k] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      ai_q    <= ai_d;
      dc_q    <= dc_d;
      cal_q   <= cal_d;
      ov_q    <= ov_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    r_q      <= r_d;
    w_neg_q  <= w_neg_d;
    w_mag_q  <= w_mag_d;
    l_neg_q  <= l_neg_d;
    l_mag_q  <= l_mag_d;
    rt_rem_q <= rt_rem_d;
    rt_res_q <= rt_res_d;
    rt_bit_q <= rt_bit_d;
    dv_rem_q <= dv_rem_d;
    dv_sh_q  <= dv_sh_d;
    dv_quo_q <= dv_quo_d;
    g_q      <= g_d;
    sat_q    <= sat_d;
    st_q     <= st_d;
    og_q     <= og_d;
    ost_q    <= ost_d;
    osat_q   <= osat_d;
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.vertical_g = og_q[0];
  assign out_o.forward_g  = og_q[1];
  assign out_o.lateral_g  = og_q[2];
  assign out_o.status     = ost_q;
  assign out_o.saturated  = osat_q;

  // an accepted beat always leaves idle
  `AAP_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != S_IDLE)
  // a rejected or uncalibrated result carries no projection
  `AAP_ASSERT_IMP(a_status_zero_fields, clk_i, rst_ni, ov_q && ost_q != aap_pkg::ST_OK, og_q[0] == '0 && og_q[1] == '0 && og_q[2] == '0 && !osat_q)
  // the root of the squared norm fits the divider operand
  `AAP_ASSERT_IMP(a_root_fits, clk_i, rst_ni, state_q == S_DIVL, rt_res_q[AccW-1:RtW] == '0)
  // calibration is only ever marked at the end of the last divide
  `AAP_ASSERT_IMP(a_cal_from_div, clk_i, rst_ni, $rose(cal_q), $past(state_q == S_DIV))

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the accelerometer alignment projector
`timescale 1ns / 100ps

// one request beat as the testbench sees it
typedef struct {
  aap_pkg::opcode_e op;
  longint           v[3];
  longint           r[3];
} align_req_t;

// one expected result beat
typedef struct {
  longint           g[3];
  aap_pkg::status_e status;
  bit               sat;
} align_res_t;

// frame model plus queue of expected projections
class align_scoreboard;
  localparam int  F   = aap_pkg::AXIS_FRAC_BITS_DEF;
  localparam longint LIM = 64'sd1 << aap_pkg::NORM_BITS;

  longint     vert_ax[3], fwd_ax[3], lat_ax[3];
  bit         frame_ok;
  align_res_t expected_q[$];
  int         errors, n_cal, n_rej, n_meas, n_uncal, n_sat;

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // halve magnitudes, truncating toward zero, until all below 2^24
  function automatic void shrink_vec(longint a[3], output longint o[3]);
    longint m[3];
    foreach (m[i]) m[i] = a[i] < 0 ? -a[i] : a[i];
    while (m[0] >= LIM || m[1] >= LIM || m[2] >= LIM)
      foreach (m[i]) m[i] >>= 1;
    foreach (o[i]) o[i] = a[i] < 0 ? -m[i] : m[i];
  endfunction

  function automatic void unit_vec(longint a[3], output longint o[3]);
    longint s[3];
    longint unsigned n2, n, q, m;
    shrink_vec(a, s);
    n2 = 0;
    foreach (s[i]) n2 += (s[i] < 0 ? -s[i] : s[i]) * (s[i] < 0 ? -s[i] : s[i]);
    n = sqrt_floor(n2);
    if (n == 0) n = 1;
    foreach (s[i]) begin
      m = s[i] < 0 ? -s[i] : s[i];
      q = ((m << (F + 1)) + n) / (n << 1);
      if (q > (64'd1 << F) - 1) q = (64'd1 << F) - 1;
      o[i] = s[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_vec(longint a[3], longint b[3], output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // rounded, clipped dot product of a sample with one axis
  function automatic longint dot_axis(longint s[3], longint ax[3], inout bit sat);
    longint d;
    longint unsigned q;
    d = s[0] * ax[0] + s[1] * ax[1] + s[2] * ax[2];
    q = ((d < 0 ? -d : d) + (64'd1 << (F - 1))) >> F;
    if (d < 0) begin
      if (q > 32768) begin
        sat = 1;
        return -32768;
      end
      return -longint'(q);
    end
    if (q > 32767) begin
      sat = 1;
      return 32767;
    end
    return longint'(q);
  endfunction

  function void note_request(align_req_t rq);
    align_res_t e;
    longint lat[3], latr[3], fw[3];
    e.g = '{0, 0, 0};
    e.status = aap_pkg::ST_OK;
    e.sat = 0;
    if (rq.op == aap_pkg::OP_CAL) begin
      cross_vec(rq.v, rq.r, lat);
      if ((rq.v[0] == 0 && rq.v[1] == 0 && rq.v[2] == 0) ||
          (lat[0] == 0 && lat[1] == 0 && lat[2] == 0)) begin
        e.status = aap_pkg::ST_REJECT;
        n_rej++;
      end else begin
        shrink_vec(lat, latr);
        cross_vec(latr, rq.v, fw);
        unit_vec(rq.v, vert_ax);
        unit_vec(fw, fwd_ax);
        unit_vec(latr, lat_ax);
        frame_ok = 1;
        n_cal++;
      end
    end else if (!frame_ok) begin
      e.status = aap_pkg::ST_UNCAL;
      n_uncal++;
    end else begin
      e.g[0] = dot_axis(rq.v, vert_ax, e.sat);
      e.g[1] = dot_axis(rq.v, fwd_ax, e.sat);
      e.g[2] = dot_axis(rq.v, lat_ax, e.sat);
      n_meas++;
      if (e.sat) n_sat++;
    end
    expected_q.push_back(e);
  endfunction

  function void check_result(longint g[3], logic [1:0] status, logic sat);
    align_res_t e;
    string names[3];
    names = '{"vertical_g", "forward_g", "lateral_g"};
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    foreach (g[i])
      if (g[i] != e.g[i]) begin
        $error("%s expected %0d got %0d", names[i], e.g[i], g[i]);
        errors++;
      end
    if (status !== e.status) begin
      $error("status expected %0d got %0d", e.status, status);
      errors++;
    end
    if (sat !== e.sat) begin
      $error("saturated expected %0d got %0d", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int SW = aap_pkg::SAMPLE_BITS_DEF;

  logic clk_i, rst_ni;
  bit   no_idle;   // quiet stretch: neither side idles
  align_scoreboard frame_sb;

  aap_in_if #(.SampleBits(SW)) in_if ();
  aap_out_if out_if ();

  accel_axis_alignment_projector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, well above the slowest legal run
  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

  // result side stalls at random except in the quiet stretch
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    longint g[3];
    if (rst_ni && out_if.valid && out_if.ready) begin
      g[0] = out_if.vertical_g;
      g[1] = out_if.forward_g;
      g[2] = out_if.lateral_g;
      frame_sb.check_result(g, out_if.status, out_if.saturated);
    end
  end

  // drive one request beat and hold it until accepted
  task automatic send_beat(aap_pkg::opcode_e op, longint v[3], longint r[3]);
    align_req_t rq;
    if (!no_idle && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    rq.op = op;
    rq.v = v;
    rq.r = r;
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.vec_x  <= SW'(v[0]);
    in_if.vec_y  <= SW'(v[1]);
    in_if.vec_z  <= SW'(v[2]);
    in_if.ref_x  <= SW'(r[0]);
    in_if.ref_y  <= SW'(r[1]);
    in_if.ref_z  <= SW'(r[2]);
    do @(posedge clk_i); while (!in_if.ready);
    frame_sb.note_request(rq);
    @(negedge clk_i);
  endtask

  function automatic longint rand_comp(bit narrow);
    if (narrow) return longint'($urandom_range(0, 400)) - 200;
    return longint'(shortint'($urandom_range(0, 65535)));
  endfunction

  task automatic rand_cal();
    longint v[3], r[3];
    int     mode, k;
    bit     narrow;
    mode = $urandom_range(99);
    narrow = ($urandom_range(3) == 0);
    foreach (v[i]) begin
      v[i] = rand_comp(narrow);
      r[i] = rand_comp(narrow);
    end
    if (mode < 12) begin
      // parallel references, scaled copy of the vertical
      k = $urandom_range(0, 4);
      foreach (v[i]) begin
        v[i] = longint'($urandom_range(0, 20000)) - 10000;
        r[i] = v[i] * (k == 0 ? -1 : (k == 1 ? 1 : (k == 2 ? 2 : (k == 3 ? -3 : 3))));
      end
    end else if (mode < 16) begin
      v = '{0, 0, 0};
    end else if (mode < 20) begin
      r = '{0, 0, 0};
    end
    send_beat(aap_pkg::OP_CAL, v, r);
  endtask

  task automatic rand_meas();
    longint s[3], r[3];
    bit     narrow;
    narrow = ($urandom_range(3) == 0);
    foreach (s[i]) begin
      s[i] = rand_comp(narrow);
      r[i] = rand_comp(0);   // ignored by a measure, still toggled
    end
    send_beat(aap_pkg::OP_MEAS, s, r);
  endtask

  initial begin
    longint z[3], big[3], neg[3];
    frame_sb = new();
    no_idle = 1'b0;
    z = '{0, 0, 0};
    big = '{32767, 32767, 32767};
    neg = '{-32768, -32768, -32768};
    rst_ni = 1'b0;
    in_if.valid  = 1'b0;
    in_if.opcode = aap_pkg::OP_MEAS;
    {in_if.vec_x, in_if.vec_y, in_if.vec_z} = '0;
    {in_if.ref_x, in_if.ref_y, in_if.ref_z} = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: measure with no frame, rejected calibrations, extremes
    send_beat(aap_pkg::OP_MEAS, big, z);
    send_beat(aap_pkg::OP_MEAS, neg, big);
    send_beat(aap_pkg::OP_CAL, z, '{0, 100, 0});
    send_beat(aap_pkg::OP_CAL, '{0, 0, 1000}, z);
    send_beat(aap_pkg::OP_CAL, '{0, 0, 1000}, '{0, 0, -3000});
    send_beat(aap_pkg::OP_MEAS, '{1, 2, 3}, z);
    send_beat(aap_pkg::OP_CAL, '{0, 0, 16384}, '{16384, 0, 16384});
    send_beat(aap_pkg::OP_MEAS, big, z);
    send_beat(aap_pkg::OP_MEAS, neg, z);
    send_beat(aap_pkg::OP_MEAS, '{1, -1, 0}, z);
    send_beat(aap_pkg::OP_CAL, z, z);             // rejected, frame kept
    send_beat(aap_pkg::OP_MEAS, '{100, 200, -300}, z);
    send_beat(aap_pkg::OP_CAL, neg, '{32767, -32768, 32767});
    send_beat(aap_pkg::OP_MEAS, big, z);
    send_beat(aap_pkg::OP_MEAS, neg, z);
    send_beat(aap_pkg::OP_CAL, '{1, 1, 1}, '{-1, 1, 0});
    send_beat(aap_pkg::OP_MEAS, big, z);          // diagonal axis clips
    send_beat(aap_pkg::OP_MEAS, neg, z);
    send_beat(aap_pkg::OP_CAL, '{-32768, 1, 0}, '{32767, 32767, -32768});
    send_beat(aap_pkg::OP_MEAS, '{-32768, 32767, -32768}, z);
    send_beat(aap_pkg::OP_CAL, '{0, 0, 1}, '{1, 0, 0});  // smallest vectors
    send_beat(aap_pkg::OP_MEAS, '{32767, -32768, 0}, z);

    // random: mostly measures against a random frame
    for (int n = 0; n < 950; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) begin
        // hold off until the pipeline has drained
        in_if.valid <= 1'b0;
        while (frame_sb.expected_q.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(99) < 20) rand_cal();
      else rand_meas();
    end
    in_if.valid <= 1'b0;
    no_idle = 1'b0;

    while (frame_sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);   // catch any stray beat

    $display("covered %0d calibrations, %0d rejected, %0d measures (%0d clipped), %0d uncalibrated",
             frame_sb.n_cal, frame_sb.n_rej, frame_sb.n_meas, frame_sb.n_sat,
             frame_sb.n_uncal);
    if (frame_sb.errors == 0 && frame_sb.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
